FILE: src/btll_pkg.sv
`default_nettype none
package btll_pkg;

    localparam int CHILD_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int LEAF_CNT_W = 5;
    localparam int RESULT_CAP = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_LEAF    = 2'd0,
        ST_NO_ROOT = 2'd1,
        ST_NO_LEAF = 2'd2
    } t_status;

    typedef struct packed {
        logic               lp;
        logic [CHILD_W-1:0] lc;
        logic               rp;
        logic [CHILD_W-1:0] rc;
    } t_node_ent;

    typedef struct packed {
        logic      en;
        t_node_ent data;
    } t_nd_wr;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: src/btll_if.sv
`default_nettype none
interface btll_in_if;
    import btll_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHILD_W-1:0] left_child;
    logic               left_present;
    logic [CHILD_W-1:0] right_child;
    logic               right_present;
    logic               last_node;

    modport source (
        output valid, left_child, left_present, right_child, right_present, last_node,
        input  ready
    );
    modport sink (
        input  valid, left_child, left_present, right_child, right_present, last_node,
        output ready
    );
endinterface

interface btll_out_if;
    import btll_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHILD_W-1:0] leaf_index;
    t_status            status;
    logic               last_result;

    modport source (
        output valid, leaf_index, status, last_result,
        input  ready
    );
    modport sink (
        input  valid, leaf_index, status, last_result,
        output ready
    );
endinterface
`default_nettype wire

FILE: src/btll_node_mem.sv
`default_nettype none
module btll_node_mem #(
    parameter int MAX_NODES = 16
) (
    input  wire logic                                          i_clk,
    input  wire btll_pkg::t_nd_wr                              i_wr,
    input  wire logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] i_wr_addr,
    input  wire logic                                          i_rd_en,
    input  wire logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] i_rd_addr,
    output      btll_pkg::t_node_ent                           o_rd_data
);
    import btll_pkg::*;

    t_node_ent r_mem [MAX_NODES];
    t_node_ent r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule
`default_nettype wire

FILE: src/btll_walk_queue.sv
`default_nettype none
module btll_walk_queue #(
    parameter int MAX_NODES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire btll_pkg::t_q_cmd  i_cmd,
    input  wire logic [(((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1) > btll_pkg::CHILD_W ?
                        ((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1) :
                        btll_pkg::CHILD_W)-1:0] i_push_node,
    output      btll_pkg::t_q_stat o_stat,
    output      logic [(((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1) > btll_pkg::CHILD_W ?
                        ((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1) :
                        btll_pkg::CHILD_W)-1:0] o_rd_node
);
    import btll_pkg::*;

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int NODE_W = (IDX_W > CHILD_W) ? IDX_W : CHILD_W;
    localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(MAX_NODES - 1);
    localparam logic [CNT_W-1:0] FULL_OCC = CNT_W'(MAX_NODES);

    logic [NODE_W-1:0] r_mem [MAX_NODES];
    logic [NODE_W-1:0] r_rd;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_occ, n_occ;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (i_cmd.clear) begin
            n_head = '0;
            n_tail = '0;
            n_occ  = '0;
        end else begin
            if (i_cmd.push) begin
                n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
            end
            if (i_cmd.pop) begin
                n_head = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
            end
            if (i_cmd.push && !i_cmd.pop) begin
                n_occ = r_occ + 1'b1;
            end else if (i_cmd.pop && !i_cmd.push) begin
                n_occ = r_occ - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            r_mem[r_tail] <= i_push_node;
        end
        if (i_cmd.pop && !i_cmd.clear) begin
            r_rd <= r_mem[r_head];
        end
    end

    assign o_rd_node    = r_rd;
    assign o_stat.empty = (r_occ == '0);
    assign o_stat.full  = (r_occ == FULL_OCC);

    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_OCC) else $error("queue occupancy overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop && !i_cmd.clear) |-> (r_occ != '0)) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && !i_cmd.pop && !i_cmd.clear) |-> (r_occ != FULL_OCC))
        else $error("push into full queue");

endmodule
`default_nettype wire

FILE: src/binary_tree_leaf_lister_top.sv
// binary tree leaf lister
// i_in takes one tree node per word: optional left and right child numbers and
// last_node. The node number is the load position, counted from zero per tree.
// Nodes beyond MAX_NODES are dropped. On the word with last_node the block stops
// taking input, scans the referenced flags one node per cycle for the root, then
// walks the tree breadth first out of the walk queue memory: each visited node
// takes a queue read, a node table read and an evaluate step, and one more for
// a node with two valid children, since the queue memory has a single write port.
// o_out returns the leaves in level order, one word each, the final word with
// last_result set. Without a root, or without a leaf, one status word is sent.
// A leaf word waits until the next leaf is found, so the last one is loaded into
// the output register after the walk has ended. Input is taken again once
// the final word is loaded into the output register, which holds it while the
// receiver stalls; a stall on o_out also holds the walk when a second leaf waits.
// Reset (synchronous, active low) empties the tree, queue and output register.
`default_nettype none
module binary_tree_leaf_lister_top #(
    parameter int MAX_NODES = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    btll_in_if.sink    i_in,
    btll_out_if.source o_out
);
    import btll_pkg::*;

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int NODE_W = (IDX_W > CHILD_W) ? IDX_W : CHILD_W;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_NODE  = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_RIGHT = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [MAX_NODES-1:0]  r_ref, n_ref;
    logic [CNT_W-1:0]      r_scan, n_scan;
    logic [CNT_W-1:0]      r_visits, n_visits;
    logic [LEAF_CNT_W-1:0] r_leaves, n_leaves;
    logic                  r_pend_v, n_pend_v;
    logic [NODE_W-1:0]     r_pend_idx, n_pend_idx;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [CHILD_W-1:0]    r_rc, n_rc;
    logic                  r_noroot, n_noroot;

    logic                  r_out_valid;
    logic [CHILD_W-1:0]    r_out_leaf;
    t_status               r_out_status;
    logic                  r_out_last;

    logic                  in_acc;
    logic                  out_free;
    logic                  ld_out;
    logic [CHILD_W-1:0]    ld_leaf;
    t_status               ld_status;
    logic                  ld_last;

    t_nd_wr                nd_wr;
    logic                  nd_rd_en;
    t_node_ent             nd_rd;
    t_q_cmd                q_cmd;
    logic [NODE_W-1:0]     q_push_node;
    t_q_stat               q_stat;
    logic [NODE_W-1:0]     q_rd_node;
    logic                  hl, hr;

    assign i_in.ready = (r_state == S_LOAD);
    assign in_acc     = i_in.valid && (r_state == S_LOAD);
    assign out_free   = !r_out_valid || o_out.ready;

    assign nd_wr.en      = in_acc && (32'(r_count) < MAX_NODES);
    assign nd_wr.data.lp = i_in.left_present;
    assign nd_wr.data.lc = i_in.left_child;
    assign nd_wr.data.rp = i_in.right_present;
    assign nd_wr.data.rc = i_in.right_child;

    assign hl = nd_rd.lp && (32'(nd_rd.lc) < 32'(r_count));
    assign hr = nd_rd.rp && (32'(nd_rd.rc) < 32'(r_count));

    btll_node_mem #(.MAX_NODES(MAX_NODES)) u_node_mem (
        .i_clk     (i_clk),
        .i_wr      (nd_wr),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_rd_en   (nd_rd_en),
        .i_rd_addr (IDX_W'(q_rd_node)),
        .o_rd_data (nd_rd)
    );

    btll_walk_queue #(.MAX_NODES(MAX_NODES)) u_walk_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_push_node (q_push_node),
        .o_stat      (q_stat),
        .o_rd_node   (q_rd_node)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ref       = r_ref;
        n_scan      = r_scan;
        n_visits    = r_visits;
        n_leaves    = r_leaves;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_node      = r_node;
        n_rc        = r_rc;
        n_noroot    = r_noroot;
        q_cmd       = '0;
        q_push_node = '0;
        nd_rd_en    = 1'b0;
        ld_out      = 1'b0;
        ld_leaf     = '0;
        ld_status   = ST_LEAF;
        ld_last     = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (32'(r_count) < MAX_NODES) begin
                        n_count = r_count + 1'b1;
                        for (int j = 0; j < MAX_NODES; j++) begin
                            if ((i_in.left_present && 32'(i_in.left_child) == j) ||
                                (i_in.right_present && 32'(i_in.right_child) == j)) begin
                                n_ref[j] = 1'b1;
                            end
                        end
                    end
                    if (i_in.last_node) begin
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan == r_count) begin
                    n_noroot = 1'b1;
                    n_state  = S_FIN;
                end else if (!r_ref[r_scan[IDX_W-1:0]]) begin
                    q_cmd.push  = 1'b1;
                    q_push_node = NODE_W'(r_scan);
                    n_state     = S_HEAD;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_HEAD: begin
                if (!q_stat.empty && (r_visits < r_count) &&
                    (r_leaves < LEAF_CNT_W'(RESULT_CAP))) begin
                    q_cmd.pop = 1'b1;
                    n_visits  = r_visits + 1'b1;
                    n_state   = S_NODE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_NODE: begin
                nd_rd_en = 1'b1;
                n_node   = q_rd_node;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (!hl && !hr) begin
                    if (!r_pend_v) begin
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_node;
                        n_leaves   = r_leaves + 1'b1;
                        n_state    = S_HEAD;
                    end else if (out_free) begin
                        ld_out     = 1'b1;
                        ld_leaf    = CHILD_W'(r_pend_idx);
                        n_pend_idx = r_node;
                        n_leaves   = r_leaves + 1'b1;
                        n_state    = S_HEAD;
                    end
                end else begin
                    n_rc    = nd_rd.rc;
                    n_state = S_HEAD;
                    if (hl && !q_stat.full) begin
                        q_cmd.push  = 1'b1;
                        q_push_node = NODE_W'(nd_rd.lc);
                    end
                    if (hr) begin
                        if (hl) begin
                            n_state = S_RIGHT;
                        end else if (!q_stat.full) begin
                            q_cmd.push  = 1'b1;
                            q_push_node = NODE_W'(nd_rd.rc);
                        end
                    end
                end
            end
            S_RIGHT: begin
                if (!q_stat.full) begin
                    q_cmd.push  = 1'b1;
                    q_push_node = NODE_W'(r_rc);
                end
                n_state = S_HEAD;
            end
            S_FIN: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_last = 1'b1;
                    if (r_noroot) begin
                        ld_status = ST_NO_ROOT;
                    end else if (!r_pend_v) begin
                        ld_status = ST_NO_LEAF;
                    end else begin
                        ld_leaf = CHILD_W'(r_pend_idx);
                    end
                    q_cmd.clear = 1'b1;
                    n_count     = '0;
                    n_ref       = '0;
                    n_visits    = '0;
                    n_leaves    = '0;
                    n_pend_v    = 1'b0;
                    n_noroot    = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ref       <= '0;
            r_scan      <= '0;
            r_visits    <= '0;
            r_leaves    <= '0;
            r_pend_v    <= 1'b0;
            r_noroot    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ref    <= n_ref;
            r_scan   <= n_scan;
            r_visits <= n_visits;
            r_leaves <= n_leaves;
            r_pend_v <= n_pend_v;
            r_noroot <= n_noroot;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_node     <= n_node;
        r_rc       <= n_rc;
        if (ld_out) begin
            r_out_leaf   <= ld_leaf;
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.leaf_index  = r_out_leaf;
    assign o_out.status      = r_out_status;
    assign o_out.last_result = r_out_last;

    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_leaves != '0)) else $error("pending leaf not counted");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_count == '0 && !r_pend_v && r_ref == '0))
        else $error("tree state not cleared after final word");
    a_leaf_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leaves <= LEAF_CNT_W'(RESULT_CAP)) else $error("leaf count above cap");

endmodule
`default_nettype wire
